// ===== src/rtsi_pkg.sv =====
// Shared types, register indexes and saturation helper for the ray-sphere tester.
`default_nettype none
package rtsi_pkg;

  // Radicand and root widths of the square root pipelines
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;

  // Configuration register indexes
  localparam logic [2:0] CFG_CENTER_X = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z = 3'd2;
  localparam logic [2:0] CFG_RADIUS   = 3'd3;
  localparam logic [2:0] CFG_EPSILON  = 3'd4;

  // Matrix word map: inverse affine below NRM_BASE, normal matrix up to NRM_LAST
  localparam logic [4:0] IDX_NRM_BASE = 5'd12;
  localparam logic [4:0] IDX_NRM_LAST = 5'd20;

  typedef logic [2:0][31:0] v3_t;

  // Load request carried down the pipe so matrix writes keep stream order
  typedef struct packed {
    logic        cmd;
    logic [4:0]  idx;
    logic [31:0] val;
  } ld_t;

  // Per-item side data that travels with every stage
  typedef struct packed {
    ld_t         ld;
    v3_t         o;
    v3_t         d;
    v3_t         e;     // object offset, later the object hit offset
    v3_t         dd;
    logic [31:0] a;
    logic [31:0] b;
    logic        miss;
    logic [30:0] t;
    v3_t         p;
    v3_t         n;
    logic [31:0] len;
  } side_t;

  // Clamp a wide signed value to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x[65:31] != {35{x[65]}}) begin
      r = x[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/rtsi_sqrt.sv =====
// Pipelined floor square root, one root bit per stage, with side payload.
`default_nettype none
module rtsi_sqrt import rtsi_pkg::*; #(
  parameter int PAY_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [PAY_W-1:0]  in_pay,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [PAY_W-1:0]  out_pay
);

  localparam int REM_W = ROOT_W + 2;

  logic              v_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [PAY_W-1:0]  pay_r  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic              v_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [RAD_W-1:0]  rad_i;
    logic [PAY_W-1:0]  pay_i;
    logic [REM_W+1:0]  rem2;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_head
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign pay_i  = in_pay;
    end else begin : g_tail
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign pay_i  = pay_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem2  = {rem_i, rad_i[RAD_W-1 -: 2]};
    assign trial = (REM_W + 2)'({root_i, 2'b01});
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
        root_r[k] <= {root_i[ROOT_W-2:0], ge};
        rad_r[k]  <= {rad_i[RAD_W-3:0], 2'b00};
        pay_r[k]  <= pay_i;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_pay   = pay_r[ROOT_W-1];

endmodule
`default_nettype wire

// ===== src/rtsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
`default_nettype none
module rtsi_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33,
  parameter int QUO_W = 32,
  parameter int PAY_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [PAY_W-1:0] in_pay,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic [PAY_W-1:0] out_pay
);

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int REM_W = (NUM_W > SH_W) ? NUM_W : SH_W;

  logic             v_r   [QUO_W];
  logic [REM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [PAY_W-1:0] pay_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_st
    logic             v_i;
    logic [REM_W-1:0] rem_i;
    logic [DEN_W-1:0] den_i;
    logic [QUO_W-1:0] quo_i;
    logic [PAY_W-1:0] pay_i;
    logic [REM_W-1:0] sh;
    logic             ge;

    if (k == 0) begin : g_head
      assign v_i   = in_valid;
      assign rem_i = REM_W'(in_num);
      assign den_i = in_den;
      assign quo_i = '0;
      assign pay_i = in_pay;
    end else begin : g_tail
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign quo_i = quo_r[k-1];
      assign pay_i = pay_r[k-1];
    end

    // Subtract the divisor aligned to this quotient bit when it fits
    assign sh = REM_W'(den_i) << (QUO_W - 1 - k);
    assign ge = (rem_i >= sh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_i - sh) : rem_i;
        den_r[k] <= den_i;
        quo_r[k] <= {quo_i[QUO_W-2:0], ge};
        pay_r[k] <= pay_i;
      end
    end
  end

  assign out_valid = v_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_pay   = pay_r[QUO_W-1];

endmodule
`default_nettype wire

// ===== src/transformed_ray_sphere_intersect_core.sv =====
// Throughput: one request per cycle unless the output stalls; two 32-stage square
// roots and the 32- and 31-stage dividers set the depth. Load requests give no result.
// A stalled output freezes the whole pipe. Reset (rst_n low at a clock edge)
// empties the pipe, sets both matrices to identity, center 0, radius 1.0, epsilon 0.
`default_nettype none
module transformed_ray_sphere_intersect_core import rtsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // word_index[4:0], word_value[36:5], origin_x/y/z[132:37], dir_x/y/z[228:133]
  input  logic [231:0] in_tdata,
  input  logic         in_tuser,  // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  // distance[30:0], point_x/y/z[126:31], normal_x/y/z[222:127]
  output logic [223:0] out_tdata,
  output logic         out_tuser, // hit
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int PW  = 64 - FRAC_BITS;  // width of a scaled product
  localparam int DW  = PW + 3;          // width of the discriminant
  localparam int SW  = $bits(side_t);
  localparam int NUM_W = 32 + FRAC_BITS;

  // Scaled product, rounded toward minus infinity
  function automatic logic signed [PW-1:0] mulf(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
    logic signed [63:0] p;
    p = x * y;
    return p[63:FRAC_BITS];
  endfunction

  logic en;

  // Configuration and matrix state
  v3_t                ctr_r;
  logic [30:0]        radius_r;
  logic signed [31:0] eps_r;
  logic signed [31:0] inv_r [12];
  logic signed [31:0] nm_r  [9];

  // Pipe registers
  logic  s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic  s8_v_r, s9_v_r, s10_v_r, s11_v_r, s12_v_r, s13_v_r, s14_v_r;
  side_t s0_r, s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r;
  side_t s8_r, s9_r, s10_r, s11_r, s12_r, s13_r, s14_r;
  side_t s0_nxt, s2_nxt, s3_nxt, s5_nxt, s7_nxt;
  side_t s8_nxt, s9_nxt, s10_nxt, s12_nxt;

  logic signed [PW-1:0] s1_po_r [3][3];
  logic signed [PW-1:0] s1_pd_r [3][3];
  logic signed [31:0]   s1_tr_r [3];
  logic signed [PW-1:0] s4_aa_r [3];
  logic signed [PW-1:0] s4_ab_r [3];
  logic signed [PW-1:0] s4_cc_r [3];
  logic [61-FRAC_BITS:0] s4_rr_r;
  logic signed [31:0]   s5_c_r;
  logic signed [PW-1:0] s6_bb_r, s6_ac_r;
  logic [RAD_W-1:0]     s7_rad_r;
  logic [NUM_W-1:0]     s8_num_r;
  logic [32:0]          s8_den_r;
  logic signed [PW-1:0] s9_pp_r [3];
  logic signed [PW-1:0] s9_pm_r [3];
  logic signed [PW-1:0] s11_pn_r [3][3];
  logic [63:0]          s13_sq_r [3];
  logic [63:0]          s14_s2_r;

  logic signed [65:0] oo_acc [3];
  logic signed [65:0] dd_acc [3];
  logic signed [65:0] e_acc  [3];
  logic signed [65:0] a_acc, b_acc, c_acc;
  logic signed [65:0] p_acc  [3];
  logic signed [65:0] m_acc  [3];
  logic signed [65:0] n_acc  [3];
  logic [61:0]        rsq;
  logic signed [DW-1:0] dlt;
  logic signed [DW-1:0] eps_ext;
  logic [RAD_W-1:0]   rad_nxt;
  logic signed [33:0] num;
  logic [30:0]        t_sel;
  logic [31:0]        mg13 [3];
  logic [4:0]         nidx;

  // Square root and divider links
  logic              q1_v, q2_v, d1_v;
  logic [ROOT_W-1:0] q1_root, q2_root;
  logic [SW-1:0]     q1_pay, q2_pay, d1_pay;
  logic [31:0]       d1_quo;
  side_t             q1_side, q2_side, d1_side, d2_pay;
  logic [31:0]       mg_n [3];
  logic              l0_v, l1_v, l2_v;
  logic [30:0]       l0_quo, l1_quo, l2_quo;
  logic [SW-1:0]     l0_pay;
  logic              l1_sgn, l2_sgn;
  side_t             l0_side;

  // Output register
  logic        out_v_r, out_cmd_r, out_hit_r;
  logic [30:0] out_dist_r;
  v3_t         out_p_r, out_n_r;
  logic        lane_sgn [3];
  logic [30:0] lane_quo [3];

  // Advance the whole pipe unless a result waits at the output
  assign out_tvalid = out_v_r & ~out_cmd_r;
  assign en         = ~out_tvalid | out_tready;
  assign in_tready  = en;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r    <= '0;
      radius_r <= 31'(64'd1 << FRAC_BITS);
      eps_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CENTER_X: ctr_r[0] <= cfg_wdata;
        CFG_CENTER_Y: ctr_r[1] <= cfg_wdata;
        CFG_CENTER_Z: ctr_r[2] <= cfg_wdata;
        CFG_RADIUS:   radius_r <= cfg_wdata[30:0];
        CFG_EPSILON:  eps_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Inverse affine: written when a load request leaves the entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 12; i++) begin
        inv_r[i] <= (i % 5 == 0) ? 32'(64'd1 << FRAC_BITS) : 32'sd0;
      end
    end else if (en && s0_v_r && s0_r.ld.cmd && (s0_r.ld.idx < IDX_NRM_BASE)) begin
      inv_r[s0_r.ld.idx[3:0]] <= s0_r.ld.val;
    end
  end

  // Normal matrix: written when a load request reaches the normal stage
  assign nidx = s10_r.ld.idx - IDX_NRM_BASE;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        nm_r[i] <= (i % 4 == 0) ? 32'(64'd1 << FRAC_BITS) : 32'sd0;
      end
    end else if (en && s10_v_r && s10_r.ld.cmd && (s10_r.ld.idx >= IDX_NRM_BASE)
                 && (s10_r.ld.idx <= IDX_NRM_LAST)) begin
      nm_r[nidx[3:0]] <= s10_r.ld.val;
    end
  end

  // Unpack the input request
  always_comb begin
    s0_nxt        = '0;
    s0_nxt.ld.cmd = in_tuser;
    s0_nxt.ld.idx = in_tdata[4:0];
    s0_nxt.ld.val = in_tdata[36:5];
    s0_nxt.o[0]   = in_tdata[68:37];
    s0_nxt.o[1]   = in_tdata[100:69];
    s0_nxt.o[2]   = in_tdata[132:101];
    s0_nxt.d[0]   = in_tdata[164:133];
    s0_nxt.d[1]   = in_tdata[196:165];
    s0_nxt.d[2]   = in_tdata[228:197];
  end

  // Adders and clamps between product stages
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oo_acc[i] = s1_tr_r[i] + s1_po_r[i][0] + s1_po_r[i][1] + s1_po_r[i][2];
      dd_acc[i] = s1_pd_r[i][0] + s1_pd_r[i][1] + s1_pd_r[i][2];
      e_acc[i]  = $signed(s2_r.e[i]) - $signed(ctr_r[i]);
      p_acc[i]  = $signed(s9_r.o[i]) + s9_pp_r[i];
      m_acc[i]  = $signed(s9_r.e[i]) + s9_pm_r[i];
      n_acc[i]  = s11_pn_r[i][0] + s11_pn_r[i][1] + s11_pn_r[i][2];
      mg13[i]   = s12_r.n[i][31] ? (32'd0 - s12_r.n[i]) : s12_r.n[i];
    end
    rsq   = radius_r * radius_r;
    a_acc = s4_aa_r[0] + s4_aa_r[1] + s4_aa_r[2];
    b_acc = s4_ab_r[0] + s4_ab_r[1] + s4_ab_r[2];
    c_acc = s4_cc_r[0] + s4_cc_r[1] + s4_cc_r[2] - $signed({1'b0, s4_rr_r});
  end

  // Discriminant, miss test and clamped radicand
  always_comb begin
    eps_ext = eps_r;
    dlt     = s6_bb_r - 4 * s6_ac_r;
    if (dlt[DW-1]) begin
      rad_nxt = '0;
    end else if (|dlt[DW-2:PW]) begin
      rad_nxt = {{PW{1'b1}}, {FRAC_BITS{1'b0}}};
    end else begin
      rad_nxt = {dlt[PW-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  // Near-root numerator after the first square root
  assign q1_side = q1_pay;
  assign num     = -$signed(q1_side.b) - $signed({2'b00, q1_root});

  // Clamp the distance quotient
  assign d1_side = d1_pay;
  assign t_sel   = d1_quo[31] ? 31'h7FFF_FFFF : d1_quo[30:0];

  // Side data for the stages that update fields
  always_comb begin
    s2_nxt  = s1_r;
    s3_nxt  = s2_r;
    s10_nxt = s9_r;
    s12_nxt = s11_r;
    for (int i = 0; i < 3; i++) begin
      s2_nxt.e[i]  = sat32(oo_acc[i]);
      s2_nxt.dd[i] = sat32(dd_acc[i]);
      s3_nxt.e[i]  = sat32(e_acc[i]);
      s10_nxt.p[i] = sat32(p_acc[i]);
      s10_nxt.e[i] = sat32(m_acc[i]);
      s12_nxt.n[i] = sat32(n_acc[i]);
    end
    s5_nxt      = s4_r;
    s5_nxt.a    = sat32(a_acc);
    s5_nxt.b    = sat32({b_acc[64:0], 1'b0});
    s7_nxt      = s6_r;
    s7_nxt.miss = (dlt < eps_ext) || (s6_r.a == 32'd0);
    s8_nxt      = q1_side;
    s8_nxt.miss = q1_side.miss | num[33];
    s9_nxt      = d1_side;
    s9_nxt.t    = t_sel;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0; s1_v_r  <= 1'b0; s2_v_r  <= 1'b0; s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0; s5_v_r  <= 1'b0; s6_v_r  <= 1'b0; s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0; s9_v_r  <= 1'b0; s10_v_r <= 1'b0; s11_v_r <= 1'b0;
      s12_v_r <= 1'b0; s13_v_r <= 1'b0; s14_v_r <= 1'b0; out_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r  <= in_tvalid;
      s1_v_r  <= s0_v_r;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= q1_v;
      s9_v_r  <= d1_v;
      s10_v_r <= s9_v_r;
      s11_v_r <= s10_v_r;
      s12_v_r <= s11_v_r;
      s13_v_r <= s12_v_r;
      s14_v_r <= s13_v_r;
      out_v_r <= l0_v & l1_v & l2_v;
    end
  end

  // Front half: transform, quadratic, discriminant
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;

      // Object-space products
      s1_r <= s0_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s1_po_r[i][j] <= mulf(inv_r[4*i+j], s0_r.o[j]);
          s1_pd_r[i][j] <= mulf(inv_r[4*i+j], s0_r.d[j]);
        end
        s1_tr_r[i] <= inv_r[4*i+3];
      end

      // Object origin and direction
      s2_r <= s2_nxt;

      // Offset from the center
      s3_r <= s3_nxt;

      // Quadratic products
      s4_r <= s3_r;
      for (int i = 0; i < 3; i++) begin
        s4_aa_r[i] <= mulf(s3_r.dd[i], s3_r.dd[i]);
        s4_ab_r[i] <= mulf(s3_r.dd[i], s3_r.e[i]);
        s4_cc_r[i] <= mulf(s3_r.e[i], s3_r.e[i]);
      end
      s4_rr_r <= rsq[61:FRAC_BITS];

      // A, B, C
      s5_r   <= s5_nxt;
      s5_c_r <= sat32(c_acc);

      // Discriminant products
      s6_r    <= s5_r;
      s6_bb_r <= mulf(s5_r.b, s5_r.b);
      s6_ac_r <= mulf(s5_r.a, s5_c_r);

      // Miss test and radicand
      s7_r     <= s7_nxt;
      s7_rad_r <= rad_nxt;

      // Numerator and divisor of the distance
      s8_r     <= s8_nxt;
      s8_num_r <= {num[31:0], {FRAC_BITS{1'b0}}};
      s8_den_r <= {q1_side.a, 1'b0};
    end
  end

  // Back half: hit point, normal, length
  always_ff @(posedge clk) begin
    if (en) begin
      // Distance products
      s9_r <= s9_nxt;
      for (int i = 0; i < 3; i++) begin
        s9_pp_r[i] <= mulf({1'b0, t_sel}, d1_side.d[i]);
        s9_pm_r[i] <= mulf({1'b0, t_sel}, d1_side.dd[i]);
      end

      // World point and object hit offset
      s10_r <= s10_nxt;

      // Normal matrix products
      s11_r <= s10_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s11_pn_r[i][j] <= mulf(nm_r[3*i+j], s10_r.e[j]);
        end
      end

      // Transformed normal
      s12_r <= s12_nxt;

      // Squared magnitudes
      s13_r <= s12_r;
      for (int i = 0; i < 3; i++) begin
        s13_sq_r[i] <= mg13[i] * mg13[i];
      end

      // Squared length
      s14_r    <= s13_r;
      s14_s2_r <= s13_sq_r[0] + s13_sq_r[1] + s13_sq_r[2];
    end
  end

  rtsi_sqrt #(.PAY_W(SW)) u_root_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s7_v_r),
    .in_rad   (s7_rad_r),
    .in_pay   (s7_r),
    .out_valid(q1_v),
    .out_root (q1_root),
    .out_pay  (q1_pay)
  );

  rtsi_div #(.NUM_W(NUM_W), .DEN_W(33), .QUO_W(32), .PAY_W(SW)) u_div_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s8_v_r),
    .in_num   (s8_num_r),
    .in_den   (s8_den_r),
    .in_pay   (s8_r),
    .out_valid(d1_v),
    .out_quo  (d1_quo),
    .out_pay  (d1_pay)
  );

  rtsi_sqrt #(.PAY_W(SW)) u_root_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s14_v_r),
    .in_rad   (s14_s2_r),
    .in_pay   (s14_r),
    .out_valid(q2_v),
    .out_root (q2_root),
    .out_pay  (q2_pay)
  );

  // Attach the length and split the normal into magnitudes
  always_comb begin
    q2_side    = q2_pay;
    d2_pay     = q2_side;
    d2_pay.len = q2_root;
    for (int i = 0; i < 3; i++) begin
      mg_n[i] = q2_side.n[i][31] ? (32'd0 - q2_side.n[i]) : q2_side.n[i];
    end
  end

  rtsi_div #(.NUM_W(62), .DEN_W(32), .QUO_W(31), .PAY_W(SW)) u_div_nx (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (q2_v),
    .in_num   ({mg_n[0], 30'd0}),
    .in_den   (q2_root),
    .in_pay   (d2_pay),
    .out_valid(l0_v),
    .out_quo  (l0_quo),
    .out_pay  (l0_pay)
  );

  rtsi_div #(.NUM_W(62), .DEN_W(32), .QUO_W(31), .PAY_W(1)) u_div_ny (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (q2_v),
    .in_num   ({mg_n[1], 30'd0}),
    .in_den   (q2_root),
    .in_pay   (q2_side.n[1][31]),
    .out_valid(l1_v),
    .out_quo  (l1_quo),
    .out_pay  (l1_sgn)
  );

  rtsi_div #(.NUM_W(62), .DEN_W(32), .QUO_W(31), .PAY_W(1)) u_div_nz (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (q2_v),
    .in_num   ({mg_n[2], 30'd0}),
    .in_den   (q2_root),
    .in_pay   (q2_side.n[2][31]),
    .out_valid(l2_v),
    .out_quo  (l2_quo),
    .out_pay  (l2_sgn)
  );

  always_comb begin
    l0_side     = l0_pay;
    lane_sgn[0] = l0_side.n[0][31];
    lane_sgn[1] = l1_sgn;
    lane_sgn[2] = l2_sgn;
    lane_quo[0] = l0_quo;
    lane_quo[1] = l1_quo;
    lane_quo[2] = l2_quo;
  end

  // Result register: zero every field on a miss
  always_ff @(posedge clk) begin
    if (en) begin
      out_cmd_r  <= l0_side.ld.cmd;
      out_hit_r  <= ~l0_side.miss;
      out_dist_r <= l0_side.miss ? 31'd0 : l0_side.t;
      for (int i = 0; i < 3; i++) begin
        out_p_r[i] <= l0_side.miss ? 32'd0 : l0_side.p[i];
        if (l0_side.miss || (l0_side.len == 32'd0)) begin
          out_n_r[i] <= 32'd0;
        end else if (lane_sgn[i]) begin
          out_n_r[i] <= 32'd0 - {1'b0, lane_quo[i]};
        end else begin
          out_n_r[i] <= {1'b0, lane_quo[i]};
        end
      end
    end
  end

  assign out_tuser = out_hit_r;
  assign out_tdata = {1'b0, out_n_r[2], out_n_r[1], out_n_r[0],
                      out_p_r[2], out_p_r[1], out_p_r[0], out_dist_r};

endmodule
`default_nettype wire

// ===== tb/rtsi_checker.sv =====
// Scoreboard for the ray-sphere tester: predicts each ray result and compares it.
`default_nettype none
module rtsi_checker import rtsi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [231:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [223:0] out_tdata,
  input  logic         out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  output int           fail_count,
  output int           pending_rays,
  output int           hits_seen,
  output int           rays_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;

  typedef struct {
    logic        hit;
    logic [30:0] t_val;
    logic [31:0] pt [3];
    logic [31:0] nrm [3];
  } ray_result_t;

  longint cen [3];
  longint radius;
  longint eps;
  longint inv_aff [12];
  longint nrm_mat [9];
  ray_result_t expected_rays [$];

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Floor shift by the fraction bits
  function automatic longint fshr(longint x);
    return x >>> FB;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned magn(longint x);
    return x < 0 ? 64'd0 - longint'(x) : x;
  endfunction

  function automatic void reset_model();
    foreach (cen[i]) cen[i] = 0;
    radius = 1 << FB;
    eps = 0;
    foreach (inv_aff[i]) inv_aff[i] = 0;
    foreach (nrm_mat[i]) nrm_mat[i] = 0;
    inv_aff[0] = 1 << FB; inv_aff[5] = 1 << FB; inv_aff[10] = 1 << FB;
    nrm_mat[0] = 1 << FB; nrm_mat[4] = 1 << FB; nrm_mat[8] = 1 << FB;
  endfunction

  function automatic ray_result_t trace_ray(logic [231:0] td);
    ray_result_t r;
    longint o [3], d [3], dd [3], e [3], m [3], n [3];
    longint so, sd, a, b, c, delta, num, acc;
    longint unsigned dl, sq, t, len, s2, q;
    r.hit = 0;
    r.t_val = 0;
    for (int i = 0; i < 3; i++) begin
      r.pt[i] = 0;
      r.nrm[i] = 0;
      o[i] = longint'($signed(td[37 + 32*i +: 32]));
      d[i] = longint'($signed(td[133 + 32*i +: 32]));
    end
    for (int i = 0; i < 3; i++) begin
      so = inv_aff[4*i + 3];
      sd = 0;
      for (int j = 0; j < 3; j++) begin
        so += fshr(inv_aff[4*i + j] * o[j]);
        sd += fshr(inv_aff[4*i + j] * d[j]);
      end
      dd[i] = clamp32(sd);
      e[i] = clamp32(clamp32(so) - cen[i]);
    end
    a = 0; b = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      a += fshr(dd[i] * dd[i]);
      b += fshr(dd[i] * e[i]);
      c += fshr(e[i] * e[i]);
    end
    c -= longint'((longint'(radius) * radius) >> FB);
    a = clamp32(a); b = clamp32(2 * b); c = clamp32(c);
    delta = fshr(b * b) - 4 * fshr(a * c);
    if (delta < eps || a == 0) return r;
    dl = delta < 0 ? 0 : delta;
    if (dl > (64'hFFFF_FFFF_FFFF_FFFF >> FB)) dl = 64'hFFFF_FFFF_FFFF_FFFF >> FB;
    sq = int_sqrt(dl << FB);
    num = -b - longint'(sq);
    if (num < 0) return r;
    t = (longint'(num) << FB) / (longint'(a) * 2);
    if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
    for (int i = 0; i < 3; i++) begin
      r.pt[i] = clamp32(o[i] + fshr(longint'(t) * d[i]));
      m[i] = clamp32(e[i] + fshr(longint'(t) * dd[i]));
    end
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += fshr(nrm_mat[3*i + j] * m[j]);
      n[i] = clamp32(acc);
      s2 += magn(n[i]) * magn(n[i]);
    end
    len = int_sqrt(s2);
    r.hit = 1;
    r.t_val = t[30:0];
    if (len != 0) begin
      for (int i = 0; i < 3; i++) begin
        q = (magn(n[i]) << 30) / len;
        if (q > (64'd1 << 30)) q = 64'd1 << 30;
        r.nrm[i] = n[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    hits_seen = 0;
    rays_seen = 0;
    pending_rays = 0;
    reset_model();
  end

  always @(posedge clk) begin
    ray_result_t ex;
    if (!rst_n) begin
      reset_model();
      expected_rays.delete();
    end else begin
      // Apply register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CENTER_X: cen[0] = longint'($signed(cfg_wdata));
          CFG_CENTER_Y: cen[1] = longint'($signed(cfg_wdata));
          CFG_CENTER_Z: cen[2] = longint'($signed(cfg_wdata));
          CFG_RADIUS:   radius = cfg_wdata[30:0];
          CFG_EPSILON:  eps = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      // Predict accepted requests
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          if (in_tdata[4:0] < IDX_NRM_BASE)
            inv_aff[in_tdata[4:0]] = longint'($signed(in_tdata[36:5]));
          else if (in_tdata[4:0] <= IDX_NRM_LAST)
            nrm_mat[in_tdata[4:0] - IDX_NRM_BASE] = longint'($signed(in_tdata[36:5]));
        end else begin
          expected_rays = {expected_rays, trace_ray(in_tdata)};
        end
      end
      // Compare results
      if (out_tvalid && out_tready) begin
        rays_seen++;
        if (out_tuser) hits_seen++;
        if (expected_rays.size() == 0) begin
          $error("unexpected result with no ray pending");
          fail_count++;
        end else begin
          ex = expected_rays.pop_front();
          check_field("hit", ex.hit, out_tuser);
          check_field("distance", ex.t_val, out_tdata[30:0]);
          check_field("point_x", ex.pt[0], out_tdata[62:31]);
          check_field("point_y", ex.pt[1], out_tdata[94:63]);
          check_field("point_z", ex.pt[2], out_tdata[126:95]);
          check_field("normal_x", ex.nrm[0], out_tdata[158:127]);
          check_field("normal_y", ex.nrm[1], out_tdata[190:159]);
          check_field("normal_z", ex.nrm[2], out_tdata[222:191]);
        end
      end
    end
    pending_rays = expected_rays.size();
  end
endmodule
`default_nettype wire

// ===== tb/transformed_ray_sphere_intersect_core_tb.sv =====
// Stimulus and verdict for the ray-sphere tester.
`default_nettype none
module transformed_ray_sphere_intersect_core_tb import rtsi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 143;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [231:0] in_tdata = '0;
  logic         in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [223:0] out_tdata;
  logic         out_tuser;
  logic         cfg_we = 0;
  logic [2:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;
  int           fail_count, pending_rays, hits_seen, rays_seen;
  bit           long_hold = 0;
  bit           sink_free_run = 0;

  always #6 clk = ~clk;

  transformed_ray_sphere_intersect_core i_dut (.*);

  rtsi_checker i_chk (.*);

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  // Drive one request; valid stays up after the accepting edge for a back-to-back follower
  task automatic send(input logic cmd, input logic [231:0] td, input bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    @(negedge clk);
    if (g != 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= td;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_word(input logic [4:0] idx, input logic [31:0] val);
    send(1'b1, {195'd0, val, idx});
  endtask

  task automatic ray(input logic [31:0] ox, oy, oz, dx, dy, dz, input bit no_gap = 0);
    send(1'b0, {3'd0, dz, dy, dx, oz, oy, ox, 37'd0}, no_gap);
  endtask

  task automatic rand_ray(input bit no_gap = 0);
    // Mostly rays aimed near the sphere, some raw noise
    if ($urandom_range(0, 3) == 0)
      ray(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), no_gap);
    else
      ray($signed($urandom_range(0, 65536 * 6)) - 65536 * 3,
          $signed($urandom_range(0, 65536 * 6)) - 65536 * 3, -(5 * 65536),
          $signed($urandom_range(0, 40000)) - 20000,
          $signed($urandom_range(0, 40000)) - 20000, $urandom_range(30000, 90000), no_gap);
  endtask

  // Drop valid and wait until every request has left the pipe
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (pending_rays != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic set_sphere(input logic [31:0] cx, cy, cz, r, e);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_EPSILON, e);
  endtask

  // Random stall on the result side; a long hold-off is counted here in cycles
  always @(negedge clk) begin
    if (long_hold) begin
      out_tready <= 0;
      repeat (1000) @(negedge clk);
      long_hold = 0;
    end else if (sink_free_run) begin
      out_tready <= 1;
    end else if ($urandom_range(0, 60) == 0) begin
      out_tready <= 0;
      repeat ($urandom_range(10, 50)) @(negedge clk);
    end else begin
      out_tready <= ($urandom_range(0, 9) < 7);
    end
  end

  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: axis hit, inside start, miss, tangent, behind, degenerate, extremes
    ray(32'h0, 32'h0, -(5 * ONE), 0, 0, ONE);
    ray(32'h0, 32'h0, ONE * 0, 0, 0, ONE);
    ray(3 * ONE, 0, -(5 * ONE), 0, 0, ONE);
    ray(ONE, 0, -(5 * ONE), 0, 0, ONE);
    ray(0, 0, 5 * ONE, 0, 0, ONE);
    ray(0, 0, -(5 * ONE), 0, 0, 0);
    ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    ray(0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF);
    // Loads: scale, translate, out-of-range index, zero normal matrix
    load_word(5'd0, 2 * ONE);
    load_word(5'd3, ONE);
    load_word(5'd31, 32'hFFFF_FFFF);
    load_word(5'd21, 32'h5555_AAAA);
    ray(0, 0, -(5 * ONE), 0, 0, ONE);
    for (int i = 12; i <= 20; i++) load_word(i[4:0], 0);
    ray(0, 0, -(5 * ONE), 0, 0, ONE);
    drain();

    // Registers: extremes, then zero radius with the largest epsilon
    set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    ray(0, 0, 0, ONE, ONE, ONE);
    ray(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0);
    drain();
    set_sphere(0, 0, 0, 0, 32'h7FFF_FFFF);
    ray(0, 0, -(5 * ONE), 0, 0, ONE);
    drain();

    // Random phases: set the sphere, reload matrices then many rays
    for (int ph = 0; ph < 6; ph++) begin
      set_sphere($signed($urandom_range(0, 2 * ONE)) - ONE, $signed($urandom_range(0, 2 * ONE)) - ONE,
                 $signed($urandom_range(0, 2 * ONE)) - ONE, $urandom_range(ONE / 4, 3 * ONE),
                 (ph == 5) ? $urandom : $signed($urandom_range(0, 2 * ONE)) - ONE);
      for (int i = 0; i < 21; i++) begin
        if (ph == 0) load_word(i[4:0], (i % 5 == 0 || i == 16 || i == 20 || i == 12) ? ONE : 0);
        else if ($urandom_range(0, 1))
          load_word(i[4:0], $signed($urandom_range(0, 3 * ONE)) - ONE);
      end
      for (int k = 0; k < 300; k++) begin
        if ($urandom_range(0, 40) == 0) load_word(5'($urandom_range(0, 31)), rnd_word());
        else rand_ray(ph == 2);
        // Hold off the result side while requests keep coming
        if (ph == 3 && k == 20) long_hold = 1;
      end
      if (ph == 3) sink_free_run = 0;
      drain();
    end
    // Burst against a fully open sink
    sink_free_run = 1;
    for (int k = 0; k < 80; k++) rand_ray(1);
    drain();

    $display("Covered %0d rays (%0d hits) across directed cases, register extremes and",
             rays_seen, hits_seen);
    $display("six random matrix/sphere phases with stalls on both sides.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/rtsi_pkg.sv
src/rtsi_sqrt.sv
src/rtsi_div.sv
src/transformed_ray_sphere_intersect_core.sv
tb/rtsi_checker.sv
tb/transformed_ray_sphere_intersect_core_tb.sv
